FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ATF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define ATF_NEVER(lbl, cond, msg) \
	`ATF_ASSERT(lbl, !(cond), msg)

`endif

FILE: rtl/atf_pkg.sv
// Types and constants for the axial torque force pipeline.
`default_nettype none

package atf_pkg;

	localparam int unsigned SqrtSteps = 32;
	localparam int unsigned QuotW = 31;
	localparam int unsigned AtfLatency = 76;

	localparam logic signed [31:0] ScaleReset = 32'sd65536;
	localparam logic [31:0] ForceMax = 32'h7FFF_FFFF;
	localparam logic [31:0] ForceMin = 32'h8000_0000;

	typedef struct packed {
		logic has_torque;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		logic signed [31:0] pivot_x;
		logic signed [31:0] pivot_y;
		logic signed [31:0] pivot_z;
		logic signed [31:0] torque_value;
		logic last_atom;
	} atf_in_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic saturated;
		logic zero_axis;
		logic last_out;
	} atf_out_t;

	// Per-item data that travels alongside the arithmetic.
	typedef struct packed {
		logic last;
		logic has;
		logic zax;
		logic [2:0] neg;
		logic [2:0][31:0] amag;
		logic [2:0][32:0] rad;
		logic [63:0] k;
	} atf_trk_t;

endpackage

`default_nettype wire

FILE: rtl/axial_torque_force.sv
// Each result strobes on done after stages s1-s5, the square root, the dividers and s69-s76.
// Throughput: one transaction per cycle; busy stays low, so start is always taken.
// The depth comes from the 32-step square root and the 31-step dividers, one bit per stage.
// Reset clears every valid bit (items in flight are dropped) and sets the scale to 1.0.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module axial_torque_force (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire atf_pkg::atf_in_t   item,
	output logic                    done,
	output atf_pkg::atf_out_t       result,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_wdata
);
	import atf_pkg::*;

	logic signed [31:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= ScaleReset;
		end else if (cfg_we) begin
			scale_q <= $signed(cfg_wdata);
		end
	end

	assign busy = 1'b0;

	// Stage 1: radius, axis magnitudes, largest magnitude, combined torque factor.
	logic [2:0][31:0] pos_c, axis_c, pivot_c;
	logic [2:0][31:0] amag_c;
	logic [2:0][32:0] rad_c;
	logic [31:0] m01_c, mmax_c;
	logic signed [63:0] k_c;
	logic signed [31:0] tv_c;
	atf_trk_t trk_c;

	assign pos_c = {item.pos_z, item.pos_y, item.pos_x};
	assign axis_c = {item.axis_z, item.axis_y, item.axis_x};
	assign pivot_c = {item.pivot_z, item.pivot_y, item.pivot_x};
	assign tv_c = item.torque_value;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amag_c[i] = axis_c[i][31] ? (~axis_c[i] + 32'd1) : axis_c[i];
			rad_c[i] = {pos_c[i][31], pos_c[i]} - {pivot_c[i][31], pivot_c[i]};
		end
		m01_c = (amag_c[0] > amag_c[1]) ? amag_c[0] : amag_c[1];
		mmax_c = (m01_c > amag_c[2]) ? m01_c : amag_c[2];
		k_c = tv_c * scale_q;
		trk_c.last = item.last_atom;
		trk_c.has = item.has_torque;
		trk_c.zax = 1'b0;
		trk_c.neg = {axis_c[2][31], axis_c[1][31], axis_c[0][31]};
		trk_c.amag = amag_c;
		trk_c.rad = rad_c;
		trk_c.k = k_c;
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	atf_trk_t trk_s1, trk_s2, trk_s3, trk_s4, trk_s5;
	logic [31:0] mmax_s1;
	logic [4:0] shamt_s2;
	logic [2:0][63:0] sq_s4;
	logic [63:0] sum_s5;

	// Stage 2: shift that brings the largest magnitude up to bit 30 or 31.
	logic [4:0] shamt_c;
	always_comb begin
		shamt_c = '0;
		for (int b = 0; b < 30; b++) begin
			if (mmax_s1[b]) begin
				shamt_c = 5'(30 - b);
			end
		end
		if (mmax_s1[31:30] != 2'b00) begin
			shamt_c = '0;
		end
	end

	atf_trk_t trk_c2, trk_c3;

	always_comb begin
		trk_c2 = trk_s1;
		trk_c2.zax = (mmax_s1 == 32'd0);
	end

	always_comb begin
		trk_c3 = trk_s2;
		for (int i = 0; i < 3; i++) begin
			trk_c3.amag[i] = trk_s2.amag[i] << shamt_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		trk_s1 <= trk_c;
		mmax_s1 <= mmax_c;

		trk_s2 <= trk_c2;
		shamt_s2 <= shamt_c;

		trk_s3 <= trk_c3;

		trk_s4 <= trk_s3;
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= trk_s3.amag[i] * trk_s3.amag[i];
		end

		trk_s5 <= trk_s4;
		sum_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2];
	end

	// Square root, one result bit per stage.
	logic [63:0] sq_rem_s [SqrtSteps];
	logic [63:0] sq_res_s [SqrtSteps];
	atf_trk_t sq_trk_s [SqrtSteps];
	logic sq_vld_s [SqrtSteps];

	for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
		localparam logic [63:0] Bit = 64'd1 << (62 - 2 * j);
		logic [63:0] rem_in, res_in, trial;
		atf_trk_t trk_in;
		logic vld_in;

		if (j == 0) begin : g_first
			assign rem_in = sum_s5;
			assign res_in = '0;
			assign trk_in = trk_s5;
			assign vld_in = vld_s5;
		end else begin : g_next
			assign rem_in = sq_rem_s[j - 1];
			assign res_in = sq_res_s[j - 1];
			assign trk_in = sq_trk_s[j - 1];
			assign vld_in = sq_vld_s[j - 1];
		end

		assign trial = res_in + Bit;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j] <= 1'b0;
			end else begin
				sq_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			sq_trk_s[j] <= trk_in;
			if (rem_in >= trial) begin
				sq_rem_s[j] <= rem_in - trial;
				sq_res_s[j] <= (res_in >> 1) + Bit;
			end else begin
				sq_rem_s[j] <= rem_in;
				sq_res_s[j] <= res_in >> 1;
			end
		end
	end

	// Three restoring dividers, one quotient bit per stage, on magnitudes.
	logic [2:0][61:0] dv_rem_s [QuotW];
	logic [2:0][30:0] dv_q_s [QuotW];
	logic [31:0] dv_len_s [QuotW];
	atf_trk_t dv_trk_s [QuotW];
	logic dv_vld_s [QuotW];

	for (genvar j = 0; j < QuotW; j++) begin : g_div
		localparam int unsigned B = QuotW - 1 - j;
		logic [2:0][61:0] rem_in;
		logic [2:0][30:0] q_in;
		logic [31:0] len_in;
		logic [61:0] dsub;
		atf_trk_t trk_in;
		logic vld_in;

		if (j == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					rem_in[i] = {sq_trk_s[SqrtSteps - 1].amag[i], 30'd0};
				end
			end
			assign q_in = '0;
			assign len_in = sq_res_s[SqrtSteps - 1][31:0];
			assign trk_in = sq_trk_s[SqrtSteps - 1];
			assign vld_in = sq_vld_s[SqrtSteps - 1];
		end else begin : g_next
			assign rem_in = dv_rem_s[j - 1];
			assign q_in = dv_q_s[j - 1];
			assign len_in = dv_len_s[j - 1];
			assign trk_in = dv_trk_s[j - 1];
			assign vld_in = dv_vld_s[j - 1];
		end

		assign dsub = 62'(len_in) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else begin
				dv_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			dv_trk_s[j] <= trk_in;
			dv_len_s[j] <= len_in;
			for (int i = 0; i < 3; i++) begin
				if (rem_in[i] >= dsub) begin
					dv_rem_s[j][i] <= rem_in[i] - dsub;
					dv_q_s[j][i] <= q_in[i] | (31'd1 << B);
				end else begin
					dv_rem_s[j][i] <= rem_in[i];
					dv_q_s[j][i] <= q_in[i];
				end
			end
		end
	end

	// Tail: signed unit vector, cross product, magnitude split, scaling, rounding.
	logic vld_s69, vld_s70, vld_s71, vld_s72, vld_s73, vld_s74, vld_s75, vld_s76;
	atf_trk_t trk_s69, trk_s70, trk_s71, trk_s72, trk_s73, trk_s74, trk_s75;
	logic signed [31:0] uvec_s69 [3];
	logic signed [63:0] prod_s70 [6];
	logic signed [63:0] cross_s71 [3];
	logic [2:0][63:0] cmag_s72;
	logic [63:0] kmag_s72;
	logic [2:0] fneg_s72, fneg_s73, fneg_s74, fneg_s75;
	logic [2:0][63:0] p00_s73, p01_s73, p10_s73, p11_s73;
	logic [2:0][63:0] p00_s74, p11_s74;
	logic [2:0][64:0] mid_s74;
	logic [2:0][127:0] full_s75;
	atf_out_t res_s76;

	logic signed [32:0] rad_c70 [3];
	logic [31:0] qlast_c [3];

	atf_out_t res_c;
	logic [127:0] rnd_c [3];
	logic [31:0] qv_c [3];
	logic [31:0] fv_c [3];
	logic [2:0] sat_c;
	logic big_c [3];
	logic live_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rad_c70[i] = $signed(trk_s69.rad[i]);
			qlast_c[i] = {1'b0, dv_q_s[QuotW - 1][i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s69 <= 1'b0;
			vld_s70 <= 1'b0;
			vld_s71 <= 1'b0;
			vld_s72 <= 1'b0;
			vld_s73 <= 1'b0;
			vld_s74 <= 1'b0;
			vld_s75 <= 1'b0;
			vld_s76 <= 1'b0;
		end else begin
			vld_s69 <= dv_vld_s[QuotW - 1];
			vld_s70 <= vld_s69;
			vld_s71 <= vld_s70;
			vld_s72 <= vld_s71;
			vld_s73 <= vld_s72;
			vld_s74 <= vld_s73;
			vld_s75 <= vld_s74;
			vld_s76 <= vld_s75;
		end
	end

	always_ff @(posedge clk) begin
		trk_s69 <= dv_trk_s[QuotW - 1];
		for (int i = 0; i < 3; i++) begin
			uvec_s69[i] <= dv_trk_s[QuotW - 1].neg[i] ? $signed(-qlast_c[i])
				: $signed(qlast_c[i]);
		end

		trk_s70 <= trk_s69;
		prod_s70[0] <= uvec_s69[1] * rad_c70[2];
		prod_s70[1] <= uvec_s69[2] * rad_c70[1];
		prod_s70[2] <= uvec_s69[2] * rad_c70[0];
		prod_s70[3] <= uvec_s69[0] * rad_c70[2];
		prod_s70[4] <= uvec_s69[0] * rad_c70[1];
		prod_s70[5] <= uvec_s69[1] * rad_c70[0];

		trk_s71 <= trk_s70;
		cross_s71[0] <= prod_s70[0] - prod_s70[1];
		cross_s71[1] <= prod_s70[2] - prod_s70[3];
		cross_s71[2] <= prod_s70[4] - prod_s70[5];

		trk_s72 <= trk_s71;
		kmag_s72 <= trk_s71.k[63] ? (~trk_s71.k + 64'd1) : trk_s71.k;
		for (int i = 0; i < 3; i++) begin
			cmag_s72[i] <= cross_s71[i][63] ? (~cross_s71[i] + 64'd1) : cross_s71[i];
			fneg_s72[i] <= cross_s71[i][63] ^ trk_s71.k[63];
		end

		// 64 by 64 magnitude product as four 32 by 32 partial products.
		trk_s73 <= trk_s72;
		fneg_s73 <= fneg_s72;
		for (int i = 0; i < 3; i++) begin
			p00_s73[i] <= cmag_s72[i][31:0] * kmag_s72[31:0];
			p01_s73[i] <= cmag_s72[i][31:0] * kmag_s72[63:32];
			p10_s73[i] <= cmag_s72[i][63:32] * kmag_s72[31:0];
			p11_s73[i] <= cmag_s72[i][63:32] * kmag_s72[63:32];
		end

		trk_s74 <= trk_s73;
		fneg_s74 <= fneg_s73;
		for (int i = 0; i < 3; i++) begin
			p00_s74[i] <= p00_s73[i];
			p11_s74[i] <= p11_s73[i];
			mid_s74[i] <= {1'b0, p01_s73[i]} + {1'b0, p10_s73[i]};
		end

		// The rounding half at bit 61 is folded into the final sum.
		trk_s75 <= trk_s74;
		fneg_s75 <= fneg_s74;
		for (int i = 0; i < 3; i++) begin
			full_s75[i] <= {p11_s74[i], 64'd0} + {31'd0, mid_s74[i], 32'd0}
				+ {64'd0, p00_s74[i]} + (128'd1 << 61);
		end

		res_s76 <= res_c;
	end

	// Round half away from zero at bit 62, saturate, apply the special cases.
	always_comb begin
		live_c = trk_s75.has && !trk_s75.zax;
		for (int i = 0; i < 3; i++) begin
			rnd_c[i] = full_s75[i];
			big_c[i] = |rnd_c[i][127:94];
			qv_c[i] = rnd_c[i][93:62];
			sat_c[i] = 1'b0;
			if (!fneg_s75[i]) begin
				if (big_c[i] || qv_c[i] > ForceMax) begin
					fv_c[i] = ForceMax;
					sat_c[i] = 1'b1;
				end else begin
					fv_c[i] = qv_c[i];
				end
			end else begin
				if (big_c[i] || qv_c[i] > ForceMin) begin
					fv_c[i] = ForceMin;
					sat_c[i] = 1'b1;
				end else begin
					fv_c[i] = ~qv_c[i] + 32'd1;
				end
			end
			if (!live_c) begin
				fv_c[i] = '0;
				sat_c[i] = 1'b0;
			end
		end
		res_c.force_x = $signed(fv_c[0]);
		res_c.force_y = $signed(fv_c[1]);
		res_c.force_z = $signed(fv_c[2]);
		res_c.saturated = |sat_c;
		res_c.zero_axis = trk_s75.has && trk_s75.zax;
		res_c.last_out = trk_s75.last;
	end

	assign done = vld_s76;
	assign result = res_s76;

endmodule

`default_nettype wire

FILE: rtl/atf_checker.sv
// Port-level checks for the axial torque force pipeline, bound to its top level.
`default_nettype none
`include "assert_macros.svh"

module atf_props (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire atf_pkg::atf_in_t   item,
	input wire logic               done,
	input wire atf_pkg::atf_out_t  result,
	input wire logic               cfg_we,
	input wire logic [31:0]        cfg_wdata
);
	import atf_pkg::*;

	logic zax_ok, sat_ok;

	assign zax_ok = (result.force_x == 32'sd0) && (result.force_y == 32'sd0)
		&& (result.force_z == 32'sd0) && !result.saturated;
	assign sat_ok = (result.force_x == $signed(ForceMax)) || (result.force_x == $signed(ForceMin))
		|| (result.force_y == $signed(ForceMax)) || (result.force_y == $signed(ForceMin))
		|| (result.force_z == $signed(ForceMax)) || (result.force_z == $signed(ForceMin));

	`ATF_NEVER(a_never_busy, busy, "busy rose although the pipeline never stalls")
	`ATF_ASSERT(a_latency, done |-> $past(start, AtfLatency), "result without a transaction")
	`ATF_ASSERT(a_zero_axis, (done && result.zero_axis) |-> zax_ok, "zero axis gave a force")
	`ATF_ASSERT(a_sat_clip, (done && result.saturated) |-> sat_ok, "saturated with no clip")

endmodule

bind axial_torque_force atf_props u_atf_checker (.*);

`default_nettype wire
